FILE: hw/rtl/spq_pkg.sv
// Shared types for the sorted-array priority queue: commands, status codes,
// request and response structs, controller states and cell control/flag groups.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FIELD_W = 4;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Input request: command and operand
    typedef struct packed {
        t_cmd   cmd;
        t_value value;
    } t_req;

    // Response: one per request
    typedef struct packed {
        t_status              status;
        t_value               data;
        logic [FIELD_W-1:0]   position;
        logic [FIELD_W-1:0]   count;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_SEARCH = 2'd2
    } t_state;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic ins_en;    // commit an insert this cycle
        logic occupied;  // cell index below the count
        logic is_tail;   // cell index equals the count (first free cell)
    } t_cell_ctl;

    // Per-cell compare results against the held operand
    typedef struct packed {
        logic shift;  // occupied and operand below entry: entry moves up
        logic eq;     // entry equals operand
        logic gt;     // operand above entry
    } t_cell_flags;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_array_priority_queue_core.sv
// Top level of the sorted-array priority queue: request sequencer, count,
// binary search stepper, response register and the chain of spq_cell.
// Depends on spq_pkg and spq_cell.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  request  | i_in_valid  / o_in_stall   | i_in_req  (cmd, value)
//  response | o_out_valid / i_out_stall  | o_out_rsp (status, data, position, count)
//
// Insert, remove and peek are accepted in S_IDLE and executed in S_EXEC across
// all cells in parallel. Search is accepted and started the same way, then
// probes in S_SEARCH (at most clog2(DEPTH+1) probes) until a match or an
// empty range ends it.
// One request is in flight at a time; a new one is accepted while the previous
// response still waits in the output register. Completion holds while that
// register is full and stalled. Reset (synchronous, active low) empties the
// queue; entries need no clearing.
`default_nettype none

module sorted_array_priority_queue_core #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire spq_pkg::t_req    i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output spq_pkg::t_rsp         o_out_rsp,
    input  wire logic             i_out_stall
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    t_value          r_value, n_value;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi1, n_hi1;   // search high bound, exclusive
    logic            r_out_valid, n_out_valid;
    t_rsp            r_rsp, n_rsp;

    t_value          w_entry [DEPTH];
    t_cell_flags     w_flags [DEPTH];
    t_cell_ctl       w_ctl   [DEPTH];
    logic            w_ins_en;
    t_value          w_tail;
    logic [CW:0]     w_sum;
    logic [IW-1:0]   w_mid;
    logic [CW-1:0]   w_pos;
    logic [CW+3:0]   w_pos_ext;
    logic [CW+3:0]   w_cnt_ext;
    logic            w_out_free;
    logic            w_sorted;

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_prev_entry;
        logic   w_prev_shift;
        if (g == 0) begin : g_head
            assign w_prev_entry = '0;
            assign w_prev_shift = 1'b0;
        end else begin : g_link
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_shift = w_flags[g-1].shift;
        end
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_value      (r_value),
            .i_prev_entry (w_prev_entry),
            .i_prev_shift (w_prev_shift),
            .i_ctl        (w_ctl[g]),
            .o_entry      (w_entry[g]),
            .o_flags      (w_flags[g])
        );
    end

    // Cell control and the largest entry (AND-OR select at count-1)
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].ins_en   = w_ins_en;
            w_ctl[i].occupied = (CW'(i) < r_count);
            w_ctl[i].is_tail  = (CW'(i) == r_count);
            if (CW'(i) == r_count - CW'(1)) begin
                w_tail = w_tail | w_entry[i];
            end
        end
    end

    // Search midpoint: floor((lo + hi) / 2) with hi = hi1 - 1
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi1} - (CW+1)'(1);
    assign w_mid     = w_sum[IW:1];
    assign w_pos     = CW'(w_mid) + CW'(1);
    assign w_pos_ext = {4'b0000, w_pos};

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        w_ins_en    = 1'b0;
        w_cnt_ext   = {4'b0000, r_count};
        o_in_stall  = (r_state != S_IDLE);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_req.cmd;
                    n_value = i_in_req.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_rsp.status   = ST_OK;
                    n_rsp.data     = '0;
                    n_rsp.position = '0;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_rsp.data = w_tail;
                                n_count    = r_count - CW'(1);
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_rsp.data = w_tail;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                // start the search, no response yet
                                n_out_valid = r_out_valid && i_out_stall;
                                n_lo        = '0;
                                n_hi1       = r_count;
                                n_state     = S_SEARCH;
                            end
                        end
                    endcase
                    w_cnt_ext   = {4'b0000, n_count};
                    n_rsp.count = w_cnt_ext[3:0];
                end
            end
            S_SEARCH: begin
                if (r_lo >= r_hi1) begin
                    if (w_out_free) begin
                        n_rsp.status   = ST_NOTFOUND;
                        n_rsp.data     = '0;
                        n_rsp.position = '0;
                        n_rsp.count    = w_cnt_ext[3:0];
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (w_flags[w_mid].eq) begin
                    if (w_out_free) begin
                        n_rsp.status   = ST_OK;
                        n_rsp.data     = '0;
                        n_rsp.position = w_pos_ext[3:0];
                        n_rsp.count    = w_cnt_ext[3:0];
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (w_flags[w_mid].gt) begin
                    n_lo = CW'(w_mid) + CW'(1);
                end else begin
                    n_hi1 = CW'(w_mid);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_lo    <= n_lo;
        r_hi1   <= n_hi1;
        r_rsp   <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    // Held entries stay ascending
    always_comb begin
        w_sorted = 1'b1;
        for (int i = 0; i < DEPTH - 1; i++) begin
            if ((CW'(i + 1) < r_count) && (w_entry[i] > w_entry[i+1])) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("entries out of order");

    a_count_only_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != S_EXEC) |-> (r_count == $past(r_count)))
        else $error("count changed outside execute");

    a_search_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo <= r_hi1) && (r_hi1 <= r_count)))
        else $error("search bounds broken");

    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

endmodule

`default_nettype wire

FILE: hw/rtl/spq_cell.sv
// One cell of the sorted chain: holds a single entry, compares it with the
// operand and takes its lower neighbour's entry or the operand on insert.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic                 i_clk,
    input  wire spq_pkg::t_value      i_value,
    input  wire spq_pkg::t_value      i_prev_entry,
    input  wire logic                 i_prev_shift,
    input  wire spq_pkg::t_cell_ctl   i_ctl,
    output spq_pkg::t_value           o_entry,
    output spq_pkg::t_cell_flags      o_flags
);
    import spq_pkg::*;

    t_value r_entry;

    // Compare flags (signed)
    always_comb begin
        o_flags.shift = i_ctl.occupied && (i_value < r_entry);
        o_flags.eq    = (i_value == r_entry);
        o_flags.gt    = (i_value > r_entry);
    end

    // Insert: take neighbour's entry if it moves up, else the operand if this
    // is the insertion slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (i_prev_shift) begin
                r_entry <= i_prev_entry;
            end else if (o_flags.shift || i_ctl.is_tail) begin
                r_entry <= i_value;
            end
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: sim/sorted_array_priority_queue_core_tb.sv
// Self-checking testbench for sorted_array_priority_queue_core: directed and random
// requests against an in-bench model of the sorted queue, with bursty input and stalled output.
// Depends on spq_pkg and the core RTL.

module sorted_array_priority_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QDEPTH    = 8;
    localparam int N_RANDOM  = 1600;
    localparam int POOL_SIZE = 10;
    localparam int MAX_REPORTS = 30;
    localparam t_value V_MIN = 32'sh8000_0000;
    localparam t_value V_MAX = 32'sh7fff_ffff;

    typedef struct {
        t_req req;
        bit   drain;   // hold this request back until every response is in
    } t_stim_item;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } t_rx_mode;

    logic   i_clk;
    logic   i_rst_n   = 1'b0;
    logic   in_valid  = 1'b0;
    t_req   in_req    = '0;
    logic   out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_rsp   o_out_rsp;

    // queue model state
    t_value pq_entry [QDEPTH];
    int     pq_count = 0;

    t_stim_item stim_q[$];
    t_rsp       rsp_expected[$];
    t_value     val_pool [POOL_SIZE];

    logic   req_taken = 1'b0;
    int     n_req_acc = 0;
    int     n_mism    = 0;
    int     gen_occ   = 0;

    // sender burst/gap state
    int     burst_left = 1;
    int     gap_left   = 0;

    // receiver stall state
    t_rx_mode rx_mode  = RX_FREE;
    int     rx_phase_left = 0;
    int     rx_hold       = 0;
    int     next_hold_at  = 400;

    sorted_array_priority_queue_core #(
        .DEPTH(QDEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_stall (out_stall)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Apply one request to the queue model and return the response it should give
    function automatic t_rsp pq_apply(t_req r);
        t_rsp rsp;
        int   i;
        int   lo;
        int   hi;
        int   mid;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.cmd)
            CMD_INSERT: begin
                if (pq_count >= QDEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // equal entries stay below the new one
                    i = pq_count - 1;
                    while (i >= 0 && r.value < pq_entry[i]) begin
                        pq_entry[i+1] = pq_entry[i];
                        i--;
                    end
                    pq_entry[i+1] = r.value;
                    pq_count++;
                end
            end
            CMD_REMOVE: begin
                if (pq_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data = pq_entry[pq_count-1];
                    pq_count--;
                end
            end
            CMD_PEEK: begin
                if (pq_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data = pq_entry[pq_count-1];
                end
            end
            CMD_SEARCH: begin
                if (pq_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.status = ST_NOTFOUND;
                    lo = 0;
                    hi = pq_count - 1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (pq_entry[mid] == r.value) begin
                            rsp.position = 4'(mid + 1);
                            rsp.status = ST_OK;
                            break;
                        end else if (r.value > pq_entry[mid]) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                end
            end
        endcase
        rsp.count = 4'(pq_count);
        return rsp;
    endfunction

    // Queue a request; gen_occ roughly follows the fill level to steer the mix
    function automatic void add_item(t_cmd c, t_value v, bit drain);
        t_stim_item it;
        it.req.cmd   = c;
        it.req.value = v;
        it.drain     = drain;
        stim_q.push_back(it);
        if (c == CMD_INSERT && gen_occ < QDEPTH)
            gen_occ++;
        else if (c == CMD_REMOVE && gen_occ > 0)
            gen_occ--;
    endfunction

    // Mostly values from a small pool so duplicates and search hits are common
    function automatic t_value pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return val_pool[$urandom_range(0, POOL_SIZE-1)];
        if (roll == 6) begin
            case ($urandom_range(0, 3))
                0: return V_MIN;
                1: return V_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return t_value'($urandom);
    endfunction

    function automatic bit field_off(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b0;
        if (n_mism < MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        return 1'b1;
    endfunction

    // Request driver: bursts with random gaps, payload held until taken
    always @(negedge i_clk) begin
        t_stim_item it;
        if (i_rst_n && !(in_valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (stim_q.size() == 0 ||
                         (stim_q[0].drain && rsp_expected.size() != 0)) begin
                in_valid <= 1'b0;
            end else begin
                it = stim_q.pop_front();
                in_req   <= it.req;
                in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Response stall pattern, with long hold-offs that back the queue up
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            out_stall <= 1'b1;
        end else if (n_req_acc >= next_hold_at) begin
            rx_hold      = 150;
            next_hold_at = next_hold_at + 800;
            out_stall <= 1'b1;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       = t_rx_mode'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(16, 96);
            end else begin
                rx_phase_left--;
            end
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: out_stall <= !out_stall;
            endcase
        end
    end

    // Monitor: check responses in order, predict each accepted request
    always @(posedge i_clk) begin
        t_rsp want;
        bit   bad;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (rsp_expected.size() == 0) begin
                    if (n_mism < MAX_REPORTS)
                        $display("%0t: response with none expected, expected nothing, got %h",
                                 $time, o_out_rsp);
                    n_mism++;
                end else begin
                    want = rsp_expected.pop_front();
                    bad = field_off("status", want.status, o_out_rsp.status)
                        | field_off("data", want.data, o_out_rsp.data)
                        | field_off("position", want.position, o_out_rsp.position)
                        | field_off("count", want.count, o_out_rsp.count);
                    if (bad)
                        n_mism++;
                end
            end
            if (in_valid && !o_in_stall) begin
                rsp_expected.push_back(pq_apply(in_req));
                n_req_acc++;
            end
            req_taken <= in_valid && !o_in_stall;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int  roll;
        bit  fill_mode;
        t_cmd c;

        for (int k = 0; k < POOL_SIZE; k++)
            val_pool[k] = (k < 4) ? t_value'($urandom_range(0, 20)) - 10 : t_value'($urandom);

        // directed: empty cases, extremes, duplicates, full, search hits and misses
        add_item(CMD_PEEK,   t_value'($urandom), 1'b0);
        add_item(CMD_REMOVE, t_value'($urandom), 1'b0);
        add_item(CMD_SEARCH, 32'sd0, 1'b0);
        add_item(CMD_INSERT, 32'sd0, 1'b0);
        add_item(CMD_INSERT, V_MIN, 1'b0);
        add_item(CMD_INSERT, V_MAX, 1'b0);
        add_item(CMD_INSERT, 32'sd0, 1'b0);
        add_item(CMD_INSERT, -32'sd1, 1'b0);
        add_item(CMD_INSERT, 32'sd5, 1'b0);
        add_item(CMD_INSERT, 32'sd5, 1'b0);
        add_item(CMD_INSERT, 32'sd100, 1'b0);
        add_item(CMD_INSERT, 32'sd7, 1'b0);
        add_item(CMD_SEARCH, V_MIN, 1'b0);
        add_item(CMD_SEARCH, V_MAX, 1'b0);
        add_item(CMD_SEARCH, 32'sd0, 1'b0);
        add_item(CMD_SEARCH, 32'sd5, 1'b0);
        add_item(CMD_SEARCH, 32'sd3, 1'b0);
        add_item(CMD_PEEK,   32'sd0, 1'b0);
        add_item(CMD_REMOVE, 32'sd0, 1'b0);
        add_item(CMD_REMOVE, 32'sd0, 1'b0);
        add_item(CMD_REMOVE, 32'sd0, 1'b0);
        add_item(CMD_SEARCH, V_MAX, 1'b0);
        add_item(CMD_SEARCH, -32'sd1, 1'b0);

        // random: swing between filling and draining so full and empty both recur
        fill_mode = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (gen_occ == QDEPTH)
                fill_mode = 1'b0;
            else if (gen_occ == 0)
                fill_mode = 1'b1;
            else if ($urandom_range(0, 29) == 0)
                fill_mode = !fill_mode;
            if ($urandom_range(0, 199) == 0)
                val_pool[$urandom_range(0, POOL_SIZE-1)] = t_value'($urandom);
            roll = $urandom_range(0, 99);
            if (fill_mode)
                c = (roll < 55) ? CMD_INSERT : (roll < 67) ? CMD_REMOVE :
                    (roll < 77) ? CMD_PEEK : CMD_SEARCH;
            else
                c = (roll < 15) ? CMD_INSERT : (roll < 60) ? CMD_REMOVE :
                    (roll < 70) ? CMD_PEEK : CMD_SEARCH;
            add_item(c, (c == CMD_INSERT || c == CMD_SEARCH) ? pick_value()
                                                             : t_value'($urandom),
                     n == 0 || n == 800);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (n_mism == 0 && rsp_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
